// File: hdl/mqrb_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-queue ring buffer: sizes, operation and status codes,
// and the command/status structs between controller and datapath. No dependencies.
package mqrb_pkg;

  localparam int NUM_QUEUES    = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int PAYLOAD_WIDTH = 32;

  // Fixed field widths of the request and response channels
  localparam int CMD_W  = 1;
  localparam int QID_W  = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int TKT_W  = 2;

  localparam int QIDX_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int ENTRY_W   = PAYLOAD_WIDTH + TKT_W;

  typedef enum logic [CMD_W-1:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic load;     // latch the incoming request
    logic exec;     // update queue state, write or read the entry store
    logic capture;  // take the entry store read data into the response
  } dp_cmd_t;

  typedef struct packed {
    logic pop_hit;  // latched request is a dequeue that will read an entry
  } dp_status_t;

endpackage

// File: hdl/mqrb_req_if.sv
`timescale 1ns / 1ps
// Request channel of the multi-queue ring buffer: valid/ready plus payload.
// Depends on mqrb_pkg.
interface mqrb_req_if
  import mqrb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [QID_W-1:0]  queue_id;
  logic [DATA_W-1:0] ticket_payload;

  modport source (output valid, cmd, queue_id, ticket_payload, input ready);
  modport sink   (input valid, cmd, queue_id, ticket_payload, output ready);
endinterface

// File: hdl/mqrb_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the multi-queue ring buffer: valid/ready plus payload.
// Depends on mqrb_pkg.
interface mqrb_rsp_if
  import mqrb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TKT_W-1:0]  ticket_number;
  logic [DATA_W-1:0] payload_out;

  modport source (output valid, status, ticket_number, payload_out, input ready);
  modport sink   (input valid, status, ticket_number, payload_out, output ready);
endinterface

// File: hdl/multi_queue_ring_buffer.sv
`timescale 1ns / 1ps
// Multi-queue ring buffer: four circular FIFOs of four entries in one shared
// entry store. Each request enqueues a word into, or dequeues one from, the
// queue named by queue_id; the response gives status, ticket number and the
// popped payload. One request is in flight at a time: after the accept the
// controller passes through its execute state and then raises response valid;
// a successful dequeue passes through an extra read state first because the
// entry store read is registered. The next request is accepted only after the
// response is taken and the controller is back in idle. Depends on mqrb_pkg,
// mqrb_req_if, mqrb_rsp_if, mqrb_ctrl and mqrb_dp.
module multi_queue_ring_buffer
  import mqrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mqrb_req_if.sink   req_i,
  mqrb_rsp_if.source rsp_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  mqrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  mqrb_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dp_cmd_i         (dp_cmd),
    .dp_status_o      (dp_status),
    .cmd_i            (req_i.cmd),
    .queue_id_i       (req_i.queue_id),
    .ticket_payload_i (req_i.ticket_payload),
    .status_o         (rsp_o.status),
    .ticket_number_o  (rsp_o.ticket_number),
    .payload_out_o    (rsp_o.payload_out)
  );

endmodule

// File: hdl/mqrb_ctrl.sv
`timescale 1ns / 1ps
// Controller of the multi-queue ring buffer: sequences accept, execute,
// entry read and response. Depends on mqrb_pkg.
module mqrb_ctrl
  import mqrb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  input  dp_status_t dp_status_i,
  output dp_cmd_t    dp_cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_e;

  state_e state_q;

  assign req_ready_o      = (state_q == S_IDLE);
  assign rsp_valid_o      = (state_q == S_RESP);
  assign dp_cmd_o.load    = (state_q == S_IDLE) && req_valid_i;
  assign dp_cmd_o.exec    = (state_q == S_EXEC);
  assign dp_cmd_o.capture = (state_q == S_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          // a successful pop goes through S_READ for the registered entry read
          state_q <= dp_status_i.pop_hit ? S_READ : S_RESP;
        end
        S_READ: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (rsp_ready_i) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/mqrb_dp.sv
`timescale 1ns / 1ps
// Datapath of the multi-queue ring buffer: per-queue pointers and occupancy,
// the shared entry store, and the response registers. Depends on mqrb_pkg.
module mqrb_dp
  import mqrb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           dp_cmd_i,
  output dp_status_t        dp_status_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [QID_W-1:0]  queue_id_i,
  input  logic [DATA_W-1:0] ticket_payload_i,
  output logic [STAT_W-1:0] status_o,
  output logic [TKT_W-1:0]  ticket_number_o,
  output logic [DATA_W-1:0] payload_out_o
);

  // latched request
  logic [CMD_W-1:0]         cmd_q;
  logic [QID_W-1:0]         qid_q;
  logic [PAYLOAD_WIDTH-1:0] data_q;

  // queue state
  logic [PTR_W-1:0] head_q [NUM_QUEUES];
  logic [PTR_W-1:0] tail_q [NUM_QUEUES];
  logic [OCC_W-1:0] occ_q  [NUM_QUEUES];

  logic [ENTRY_W-1:0] mem [MEM_DEPTH];
  logic [ENTRY_W-1:0] rd_data_q;

  logic [STAT_W-1:0] status_q;
  logic [TKT_W-1:0]  ticket_q;
  logic [DATA_W-1:0] payload_q;

  logic              in_range;
  logic [QIDX_W-1:0] q_idx;
  logic              is_deq;
  logic              push_ok;
  logic              pop_ok;
  logic [PTR_W-1:0]  head_cur;
  logic [PTR_W-1:0]  tail_cur;
  logic [OCC_W-1:0]  occ_cur;
  logic [PTR_W-1:0]  head_nxt;
  logic [PTR_W-1:0]  tail_nxt;
  logic [MEM_AW-1:0] wr_addr;
  logic [MEM_AW-1:0] rd_addr;

  assign in_range = (int'(qid_q) < NUM_QUEUES);
  assign q_idx    = QIDX_W'(qid_q);
  assign is_deq   = (cmd_q == OP_DEQ);
  assign head_cur = head_q[q_idx];
  assign tail_cur = tail_q[q_idx];
  assign occ_cur  = occ_q[q_idx];
  assign push_ok  = !is_deq && in_range && (occ_cur != OCC_W'(QUEUE_DEPTH));
  assign pop_ok   = is_deq && in_range && (occ_cur != '0);

  // wrap pointers at the queue depth
  assign head_nxt = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
  assign tail_nxt = (tail_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + 1'b1;

  assign wr_addr = MEM_AW'(q_idx) * MEM_AW'(QUEUE_DEPTH) + MEM_AW'(tail_cur);
  assign rd_addr = MEM_AW'(q_idx) * MEM_AW'(QUEUE_DEPTH) + MEM_AW'(head_cur);

  assign dp_status_o.pop_hit = pop_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
      end
    end else if (dp_cmd_i.exec) begin
      if (push_ok) begin
        tail_q[q_idx] <= tail_nxt;
        occ_q[q_idx]  <= occ_cur + 1'b1;
      end else if (pop_ok) begin
        head_q[q_idx] <= head_nxt;
        occ_q[q_idx]  <= occ_cur - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.exec && push_ok) begin
      mem[wr_addr] <= {data_q, TKT_W'(occ_cur)};
    end
    if (dp_cmd_i.exec && pop_ok) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      cmd_q  <= cmd_i;
      qid_q  <= queue_id_i;
      data_q <= PAYLOAD_WIDTH'(ticket_payload_i);
    end
    if (dp_cmd_i.exec) begin
      if (push_ok) begin
        status_q  <= ST_OK;
        ticket_q  <= TKT_W'(occ_cur);
        payload_q <= '0;
      end else if (!pop_ok) begin
        status_q  <= is_deq ? ST_EMPTY : ST_FULL;
        ticket_q  <= '0;
        payload_q <= '0;
      end
    end
    if (dp_cmd_i.capture) begin
      status_q  <= ST_OK;
      ticket_q  <= rd_data_q[TKT_W-1:0];
      payload_q <= DATA_W'(rd_data_q[ENTRY_W-1:TKT_W]);
    end
  end

  assign status_o        = status_q;
  assign ticket_number_o = ticket_q;
  assign payload_out_o   = payload_q;

endmodule

// File: bench/tb_multi_queue_ring_buffer.sv
`timescale 1ns / 1ps
// Testbench for multi_queue_ring_buffer: drives enqueue/dequeue requests and
// checks each response against a queue-level prediction kept in the bench.
// Depends on mqrb_pkg, mqrb_req_if, mqrb_rsp_if and the block itself.
module tb_multi_queue_ring_buffer;
  import mqrb_pkg::*;

  typedef struct packed {
    status_e              status;
    logic [TKT_W-1:0]     ticket;
    logic [DATA_W-1:0]    payload;
  } queue_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mqrb_req_if req_if ();
  mqrb_rsp_if rsp_if ();

  multi_queue_ring_buffer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Predicted queue contents
  logic [PAYLOAD_WIDTH-1:0] q_payload [NUM_QUEUES][QUEUE_DEPTH];
  logic [TKT_W-1:0]         q_ticket  [NUM_QUEUES][QUEUE_DEPTH];
  int unsigned              q_head    [NUM_QUEUES];
  int unsigned              q_tail    [NUM_QUEUES];
  int unsigned              q_count   [NUM_QUEUES];

  queue_rsp_t expected_rsp [$];

  int  error_count;
  int  requests_sent;
  int  rsp_ok, rsp_full, rsp_empty;
  bit  src_idle_en;
  bit  sink_idle_en;
  int  hold_len;
  bit  hold_tgl;

  function automatic queue_rsp_t predict_queue_op(op_e op, logic [QID_W-1:0] qid,
                                                  logic [DATA_W-1:0] data);
    queue_rsp_t r;
    int unsigned q;
    r.status  = ST_OK;
    r.ticket  = '0;
    r.payload = '0;
    q = qid;
    if (op == OP_ENQ) begin
      if (q >= NUM_QUEUES || q_count[q] >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        q_payload[q][q_tail[q]] = data[PAYLOAD_WIDTH-1:0];
        q_ticket[q][q_tail[q]]  = TKT_W'(q_count[q]);
        r.ticket  = TKT_W'(q_count[q]);
        q_tail[q] = (q_tail[q] + 1) % QUEUE_DEPTH;
        q_count[q]++;
      end
    end else begin
      if (q >= NUM_QUEUES || q_count[q] == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.payload = DATA_W'(q_payload[q][q_head[q]]);
        r.ticket  = q_ticket[q][q_head[q]];
        q_head[q] = (q_head[q] + 1) % QUEUE_DEPTH;
        q_count[q]--;
      end
    end
    return r;
  endfunction

  // Predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      expected_rsp.push_back(predict_queue_op(op_e'(req_if.cmd), req_if.queue_id,
                                              req_if.ticket_payload));
    end
  end

  // Check every accepted response against the oldest prediction
  always @(posedge clk_i) begin
    queue_rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected response: status %0d ticket %0d payload %h",
               rsp_if.status, rsp_if.ticket_number, rsp_if.payload_out);
        error_count++;
      end else begin
        exp_rsp = expected_rsp.pop_front();
        case (exp_rsp.status)
          ST_OK:    rsp_ok++;
          ST_FULL:  rsp_full++;
          default:  rsp_empty++;
        endcase
        if (rsp_if.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, rsp_if.status);
          error_count++;
        end
        if (rsp_if.ticket_number !== exp_rsp.ticket) begin
          $error("ticket_number: expected %0d, got %0d", exp_rsp.ticket,
                 rsp_if.ticket_number);
          error_count++;
        end
        if (rsp_if.payload_out !== exp_rsp.payload) begin
          $error("payload_out: expected %h, got %h", exp_rsp.payload, rsp_if.payload_out);
          error_count++;
        end
      end
    end
  end

  // Response side: random stalls, plus a long hold-off on request
  initial begin
    int  hold_left;
    bit  hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_tgl != hold_seen) begin
        hold_seen = hold_tgl;
        hold_left = hold_len - 1;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (sink_idle_en) begin
        rsp_if.ready <= ($urandom_range(99) >= 33);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Offer one request and return at the edge that accepts it; valid stays high
  task automatic send_request(op_e op, logic [QID_W-1:0] qid, logic [DATA_W-1:0] data);
    if (src_idle_en && $urandom_range(99) < 33) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.cmd            <= op;
    req_if.queue_id       <= qid;
    req_if.ticket_payload <= data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic test_empty_queues();
    for (int q = 0; q < NUM_QUEUES; q++) begin
      send_request(OP_DEQ, QID_W'(q), '1);
    end
  endtask

  // Fill one queue past full with extreme payloads, then drain past empty
  task automatic test_fill_to_full();
    logic [DATA_W-1:0] words [5];
    words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h5A5A_5A5A};
    foreach (words[i]) send_request(OP_ENQ, QID_W'(2), words[i]);
    repeat (QUEUE_DEPTH + 1) send_request(OP_DEQ, QID_W'(2), '0);
  endtask

  // Interleave pushes and pops so head and tail wrap around
  task automatic test_pointer_wrap();
    send_request(OP_ENQ, QID_W'(1), 32'h1111_0001);
    send_request(OP_ENQ, QID_W'(1), 32'h1111_0002);
    send_request(OP_DEQ, QID_W'(1), 32'hDEAD_BEEF);
    for (int i = 3; i <= 5; i++) send_request(OP_ENQ, QID_W'(1), DATA_W'(32'h1111_0000 + i));
    repeat (QUEUE_DEPTH) send_request(OP_DEQ, QID_W'(1), '0);
  endtask

  task automatic test_random_traffic(int n_items);
    int stop_at;
    logic [QID_W-1:0] qid;
    int burst;
    stop_at = requests_sent + n_items;
    while (requests_sent < stop_at) begin
      qid = QID_W'($urandom_range(NUM_QUEUES - 1));
      case ($urandom_range(2))
        0: repeat (8) send_request(op_e'($urandom_range(1)), QID_W'($urandom_range(3)),
                                   $urandom());
        1: begin
          // Push a burst of QUEUE_DEPTH-1 to QUEUE_DEPTH+1 words, then pop as many
          burst = $urandom_range(QUEUE_DEPTH - 1, QUEUE_DEPTH + 1);
          repeat (burst) send_request(OP_ENQ, qid, $urandom());
          repeat (burst) send_request(OP_DEQ, qid, $urandom());
        end
        default: repeat (6) send_request($urandom_range(99) < 55 ? OP_ENQ : OP_DEQ,
                                         qid, $urandom());
      endcase
    end
  endtask

  // Hold responses off while requests keep coming
  task automatic test_backpressure();
    hold_len = 200;
    hold_tgl = ~hold_tgl;
    src_idle_en = 1'b0;
    repeat (30) send_request(op_e'($urandom_range(1)), QID_W'($urandom_range(3)), $urandom());
    src_idle_en = 1'b1;
  endtask

  task automatic test_streaming(int n_items);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (n_items) send_request(op_e'($urandom_range(1)), QID_W'($urandom_range(3)),
                                  $urandom());
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      q_head[q]  = 0;
      q_tail[q]  = 0;
      q_count[q] = 0;
    end
    error_count   = 0;
    requests_sent = 0;
    rsp_ok        = 0;
    rsp_full      = 0;
    rsp_empty     = 0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    hold_len      = 0;
    hold_tgl      = 1'b0;
    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.cmd            <= OP_ENQ;
    req_if.queue_id       <= '0;
    req_if.ticket_payload <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queues();
    test_fill_to_full();
    test_pointer_wrap();
    test_random_traffic(300);
    test_backpressure();
    test_streaming(150);
    test_random_traffic(150);

    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d requests; responses: %0d ok, %0d full, %0d empty.",
             requests_sent, rsp_ok, rsp_full, rsp_empty);
    $display("Included a %0d-cycle response hold-off and a back-to-back stretch.", hold_len);
    if (error_count == 0) begin
      $display("tb_multi_queue_ring_buffer: done, clean");
    end else begin
      $display("tb_multi_queue_ring_buffer: done, errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_multi_queue_ring_buffer: done, errors");
    $finish;
  end

endmodule

// File: files.f
hdl/mqrb_pkg.sv
hdl/mqrb_req_if.sv
hdl/mqrb_rsp_if.sv
hdl/mqrb_ctrl.sv
hdl/mqrb_dp.sv
hdl/multi_queue_ring_buffer.sv
bench/tb_multi_queue_ring_buffer.sv
